// File: rtl/gci_pkg.sv
package gci_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DELTA_W   = 16;
    localparam int POS_W     = 25;
    localparam int RAD_W     = 16;
    localparam int STEP_W    = 10;
    localparam int IDLE_W    = 8;
    localparam int PROD_W    = 2 * POS_W;
    // magnitude of a product of two position-range values
    localparam int QUO_W     = 2 * POS_W - 1;

    localparam int IN_DATA_W  = 2 * DELTA_W;
    localparam int OUT_DATA_W = ((2 * POS_W + 7) / 8) * 8;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = RAD_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT = 2'd2;

    localparam logic [RAD_W-1:0]  RST_MAX_RADIUS = 16'd10000;
    localparam logic [STEP_W-1:0] RST_STEP_SIZE  = 10'd10;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT = 8'd10;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_RSQ,
        ST_CMP,
        ST_STEP,
        ST_PROD,
        ST_DIV,
        ST_NEAR,
        ST_DONE
    } state_t;

    // one-bit-wider value clamped back into the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1])
        begin
            r = v[POS_W] ? POS_MIN : POS_MAX;
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/gci_mul.sv
module gci_mul (
    input  logic                                clk,
    input  logic signed [gci_pkg::POS_W-1:0]    a,
    input  logic signed [gci_pkg::POS_W-1:0]    b,
    output logic signed [gci_pkg::PROD_W-1:0]   prod
);
    import gci_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    // registered product
    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

// File: rtl/gci_div.sv
module gci_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gci_pkg::PROD_W-1:0]   dividend,
    input  logic signed [gci_pkg::POS_W-1:0]    divisor,
    output logic                                done,
    output logic signed [gci_pkg::POS_W-1:0]    quotient
);
    import gci_pkg::*;

    localparam int CNT_W = $clog2(QUO_W + 1);
    localparam logic [QUO_W-1:0] POS_LIM = QUO_W'((64'd1 << (POS_W - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] NEG_LIM = QUO_W'(64'd1 << (POS_W - 1));

    logic [QUO_W-1:0] num_reg;
    logic [POS_W-1:0] den_reg;
    logic [POS_W-1:0] rem_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [PROD_W-1:0] dvd_neg;
    logic [QUO_W-1:0]  dvd_abs;
    logic [POS_W:0]    dvs_ext;
    logic [POS_W:0]    dvs_neg;
    logic [POS_W-1:0]  dvs_abs;
    logic [POS_W:0]    rem_sh;
    logic [POS_W:0]    rem_dif;
    logic              rem_ge;
    logic [POS_W-1:0]  rem_next;
    logic [POS_W-1:0]  q_low_neg;

    assign dvd_neg = -dividend;
    assign dvd_abs = dividend[PROD_W-1] ? dvd_neg[QUO_W-1:0] : dividend[QUO_W-1:0];
    assign dvs_ext = {divisor[POS_W-1], divisor};
    assign dvs_neg = -dvs_ext;
    assign dvs_abs = divisor[POS_W-1] ? dvs_neg[POS_W-1:0] : dvs_ext[POS_W-1:0];

    // restoring step, one quotient bit per cycle
    assign rem_sh   = {rem_reg, num_reg[QUO_W-1]};
    assign rem_dif  = rem_sh - {1'b0, den_reg};
    assign rem_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_next = rem_ge ? rem_dif[POS_W-1:0] : rem_sh[POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(QUO_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dvd_abs;
            den_reg <= dvs_abs;
            rem_reg <= '0;
            neg_reg <= dividend[PROD_W-1] ^ divisor[POS_W-1];
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[QUO_W-2:0], rem_ge};
            rem_reg <= rem_next;
        end
    end

    // truncated quotient, clamped to the position range
    assign q_low_neg = -num_reg[POS_W-1:0];

    always_comb
    begin
        if (neg_reg)
        begin
            quotient = (num_reg > NEG_LIM) ? POS_MIN : q_low_neg;
        end
        else
        begin
            quotient = (num_reg > POS_LIM) ? POS_MAX : num_reg[POS_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

// File: rtl/gyro_cursor_bounded_integrator_top.sv
// Bounded gyro cursor integrator. Each input beat carries one signed gyro
// delta pair; it is scaled to Q16.8, added to a saturating accumulator, and
// one output beat returns the shown cursor position plus an at_bound flag.
// When the accumulated point reaches the circle of radius max_radius
// (compared on squares), or the same deltas have repeated more than
// idle_limit times, the cursor steps inward along its ray by step_size.
// Timing: one beat at a time. A beat that needs no inward step goes from
// acceptance to the output register through three passes of the
// shared 25x25 multiplier for x^2, y^2 and r^2, then the compare, and the
// input is ready again in the cycle after the result is loaded. An inward
// step with a nonzero x also waits on the bit-serial divider (49 quotient
// bits, one per cycle) that computes the new y on the ray; a step with x
// at zero skips the divider. s_axis_tready is high only while the
// sequencer is idle; a finished result may wait in the output register
// while the next beat is accepted. The configuration channel is always
// ready; write it only while no beat is in flight.
module gyro_cursor_bounded_integrator_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // slave side: [15:0] delta_x, [31:16] delta_y
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [gci_pkg::IN_DATA_W-1:0]           s_axis_tdata,
    // master side: [24:0] pos_x, [49:25] pos_y, [55:50] zero
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [gci_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // [0] at_bound
    output logic [0:0]                              m_axis_tuser,
    // configuration writes
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gci_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [gci_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import gci_pkg::*;

    localparam int EXT_PAD = POS_W + 1 - DELTA_W - FRAC_BITS;
    localparam int S_W     = STEP_W + FRAC_BITS;

    // configuration
    logic [RAD_W-1:0]  max_radius_reg;
    logic [STEP_W-1:0] step_size_reg;
    logic [IDLE_W-1:0] idle_limit_reg;

    // tick state
    state_t                   state_reg;
    state_t                   state_next;
    logic signed [POS_W-1:0]  accum_x_reg;
    logic signed [POS_W-1:0]  accum_y_reg;
    logic signed [POS_W-1:0]  shown_x_reg;
    logic signed [POS_W-1:0]  shown_y_reg;
    logic signed [DELTA_W-1:0] bound_dx_reg;
    logic signed [DELTA_W-1:0] bound_dy_reg;
    logic signed [DELTA_W-1:0] moved_dx_reg;
    logic signed [DELTA_W-1:0] moved_dy_reg;
    logic [IDLE_W-1:0]        idle_ticks_reg;
    logic                     bound_flag_reg;

    // working registers for the beat in flight
    logic signed [DELTA_W-1:0] dx_reg;
    logic signed [DELTA_W-1:0] dy_reg;
    logic [PROD_W-1:0]        sum_reg;
    logic signed [POS_W-1:0]  nx_reg;
    logic                     drift_reg;

    // output register
    logic                     m_valid_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic                     at_bound_reg;

    // input side
    logic signed [DELTA_W-1:0] in_dx;
    logic signed [DELTA_W-1:0] in_dy;
    logic signed [POS_W:0]    acc_x_wide;
    logic signed [POS_W:0]    acc_y_wide;
    logic signed [POS_W-1:0]  acc_x_sat;
    logic signed [POS_W-1:0]  acc_y_sat;
    logic                     restore;
    logic                     in_accept;

    // shared multiplier
    logic signed [POS_W-1:0]  mul_a;
    logic signed [POS_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    logic signed [POS_W-1:0]  radius_q;

    // compare and step
    logic                     at_bnd;
    logic                     moved_same;
    logic [IDLE_W-1:0]        idle_inc;
    logic                     drift_go;
    logic [POS_W:0]           s_ext;
    logic signed [POS_W:0]    sx_ext;
    logic signed [POS_W:0]    sy_ext;
    logic signed [POS_W:0]    nx_wide;
    logic signed [POS_W-1:0]  nx_sat;
    logic signed [POS_W:0]    ny0_wide;
    logic [POS_W:0]           abs_x;
    logic [POS_W:0]           abs_y;
    logic                     near;

    // divider
    logic                     div_start;
    logic                     div_done;
    logic signed [POS_W-1:0]  div_quo;

    logic                     m_load;

    assign in_dx     = s_axis_tdata[DELTA_W-1:0];
    assign in_dy     = s_axis_tdata[2*DELTA_W-1:DELTA_W];
    assign in_accept = s_axis_tvalid && s_axis_tready;

    // accumulate delta << FRAC_BITS with saturation
    assign acc_x_wide = {accum_x_reg[POS_W-1], accum_x_reg}
                      + {{EXT_PAD{in_dx[DELTA_W-1]}}, in_dx, {FRAC_BITS{1'b0}}};
    assign acc_y_wide = {accum_y_reg[POS_W-1], accum_y_reg}
                      + {{EXT_PAD{in_dy[DELTA_W-1]}}, in_dy, {FRAC_BITS{1'b0}}};
    assign acc_x_sat  = sat_pos(acc_x_wide);
    assign acc_y_sat  = sat_pos(acc_y_wide);
    // leaving the bound with both deltas changed snaps back to the cursor
    assign restore    = bound_flag_reg && (bound_dx_reg != in_dx) && (bound_dy_reg != in_dy);

    assign radius_q = {1'b0, max_radius_reg, {FRAC_BITS{1'b0}}};

    // squared distance vs squared radius; r^2 sits in the multiplier output
    assign at_bnd     = sum_reg >= {1'b0, mul_prod[QUO_W-1:0]};
    assign moved_same = (moved_dx_reg == dx_reg) && (moved_dy_reg == dy_reg);
    assign idle_inc   = (idle_ticks_reg == {IDLE_W{1'b1}}) ? idle_ticks_reg
                                                           : idle_ticks_reg + 1'b1;
    assign drift_go   = moved_same && (idle_inc > idle_limit_reg);

    // inward step along the ray
    assign s_ext   = {{(POS_W + 1 - S_W){1'b0}}, step_size_reg, {FRAC_BITS{1'b0}}};
    assign sx_ext  = {shown_x_reg[POS_W-1], shown_x_reg};
    assign sy_ext  = {shown_y_reg[POS_W-1], shown_y_reg};
    assign nx_wide = shown_x_reg[POS_W-1] ? sx_ext + $signed(s_ext) : sx_ext - $signed(s_ext);
    assign nx_sat  = sat_pos(nx_wide);

    always_comb
    begin
        if (shown_y_reg[POS_W-1])
        begin
            ny0_wide = sy_ext + $signed(s_ext);
        end
        else if (shown_y_reg != '0)
        begin
            ny0_wide = sy_ext - $signed(s_ext);
        end
        else
        begin
            ny0_wide = sy_ext;
        end
    end

    assign abs_x = shown_x_reg[POS_W-1] ? -sx_ext : sx_ext;
    assign abs_y = shown_y_reg[POS_W-1] ? -sy_ext : sy_ext;
    assign near  = (abs_x <= s_ext) && (abs_y <= s_ext);

    gci_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    gci_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_prod),
        .divisor  (shown_x_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_SQX;
                end
            end
            ST_SQX:  state_next = ST_SQY;
            ST_SQY:  state_next = ST_RSQ;
            ST_RSQ:  state_next = ST_CMP;
            ST_CMP:
            begin
                state_next = (at_bnd || drift_go) ? ST_STEP : ST_DONE;
            end
            ST_STEP:
            begin
                state_next = (shown_x_reg != '0) ? ST_PROD : ST_NEAR;
            end
            ST_PROD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_NEAR;
                end
            end
            ST_NEAR: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        m_load        = 1'b0;
        mul_a         = accum_x_reg;
        mul_b         = accum_x_reg;
        case (state_reg)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_SQX:
            begin
                mul_a = accum_x_reg;
                mul_b = accum_x_reg;
            end
            ST_SQY:
            begin
                mul_a = accum_y_reg;
                mul_b = accum_y_reg;
            end
            ST_RSQ:
            begin
                mul_a = radius_q;
                mul_b = radius_q;
            end
            ST_STEP:
            begin
                mul_a = shown_y_reg;
                mul_b = nx_sat;
            end
            ST_PROD: div_start = 1'b1;
            ST_DONE: m_load = !m_valid_reg || m_axis_tready;
            default:
            begin
                mul_a = accum_x_reg;
                mul_b = accum_x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_radius_reg <= RST_MAX_RADIUS;
            step_size_reg  <= RST_STEP_SIZE;
            idle_limit_reg <= RST_IDLE_LIMIT;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_RADIUS: max_radius_reg <= cfg_data;
                CFG_STEP_SIZE:  step_size_reg  <= cfg_data[STEP_W-1:0];
                CFG_IDLE_LIMIT: idle_limit_reg <= cfg_data[IDLE_W-1:0];
                default:        ;
            endcase
        end
    end

    // tick state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_x_reg    <= '0;
            accum_y_reg    <= '0;
            shown_x_reg    <= '0;
            shown_y_reg    <= '0;
            bound_dx_reg   <= '0;
            bound_dy_reg   <= '0;
            moved_dx_reg   <= '0;
            moved_dy_reg   <= '0;
            idle_ticks_reg <= '0;
            bound_flag_reg <= 1'b0;
            drift_reg      <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        accum_x_reg <= restore ? shown_x_reg : acc_x_sat;
                        accum_y_reg <= restore ? shown_y_reg : acc_y_sat;
                    end
                end
                ST_CMP:
                begin
                    if (at_bnd)
                    begin
                        bound_flag_reg <= 1'b1;
                        bound_dx_reg   <= dx_reg;
                        bound_dy_reg   <= dy_reg;
                        drift_reg      <= 1'b0;
                    end
                    else
                    begin
                        bound_flag_reg <= 1'b0;
                        drift_reg      <= 1'b1;
                        if (moved_same)
                        begin
                            idle_ticks_reg <= idle_inc;
                        end
                        else
                        begin
                            idle_ticks_reg <= '0;
                            shown_x_reg    <= accum_x_reg;
                            shown_y_reg    <= accum_y_reg;
                            moved_dx_reg   <= dx_reg;
                            moved_dy_reg   <= dy_reg;
                        end
                    end
                end
                ST_STEP:
                begin
                    if (shown_x_reg == '0)
                    begin
                        shown_y_reg <= sat_pos(ny0_wide);
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        shown_x_reg <= nx_reg;
                        shown_y_reg <= div_quo;
                    end
                end
                ST_NEAR:
                begin
                    if (near)
                    begin
                        accum_x_reg <= '0;
                        accum_y_reg <= '0;
                    end
                    else if (drift_reg)
                    begin
                        accum_x_reg <= shown_x_reg;
                        accum_y_reg <= shown_y_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // working payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            dx_reg <= in_dx;
            dy_reg <= in_dy;
        end
        if (state_reg == ST_SQY)
        begin
            sum_reg <= {1'b0, mul_prod[QUO_W-1:0]};
        end
        else if (state_reg == ST_RSQ)
        begin
            sum_reg <= sum_reg + {1'b0, mul_prod[QUO_W-1:0]};
        end
        if (state_reg == ST_STEP)
        begin
            nx_reg <= nx_sat;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (m_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_load)
        begin
            pos_x_reg    <= shown_x_reg;
            pos_y_reg    <= shown_y_reg;
            at_bound_reg <= bound_flag_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - 2*POS_W){1'b0}}, pos_y_reg, pos_x_reg};
    assign m_axis_tuser  = at_bound_reg;

    // one beat at a time
    a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("input accepted while a beat is in flight");

    // ray division only runs with a nonzero x
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROD |-> shown_x_reg != '0)
        else $error("division started with zero divisor");

    // near-origin step clears the accumulator
    a_near_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEAR) && near |=> (accum_x_reg == '0) && (accum_y_reg == '0))
        else $error("accumulator not cleared near origin");

    // the divider wait is only entered from the product state
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) && ($past(state_reg) != ST_DIV) |-> $past(state_reg) == ST_PROD)
        else $error("divider wait entered out of sequence");

endmodule
